>>> hw/rtl/utf8_dec_pkg.sv
// Shared types, constants and the double-width range table for the UTF-8 stream decoder.
`timescale 1ns / 1ps

package utf8_dec_pkg;

    localparam int unsigned CP_W      = 21;
    localparam int unsigned QDEPTH    = 3;
    localparam int unsigned N_WIDE    = 19;

    localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_2BYTE   = 21'h000080;
    localparam logic [CP_W-1:0] MIN_3BYTE   = 21'h000800;
    localparam logic [CP_W-1:0] MIN_4BYTE   = 21'h010000;

    typedef enum logic [2:0] {
        ST_VALID    = 3'd0,
        ST_BAD_LEAD = 3'd1,
        ST_TRUNC    = 3'd2,
        ST_REJECT   = 3'd3,
        ST_TERM     = 3'd4
    } status_t;

    typedef logic [CP_W-1:0] wide_range_t [0:N_WIDE-1][0:1];

    localparam wide_range_t WIDE_RANGES = '{
        '{21'h01100, 21'h0115F}, '{21'h02329, 21'h0232A}, '{21'h02E80, 21'h0303E},
        '{21'h03041, 21'h033BF}, '{21'h03400, 21'h04DBF}, '{21'h04E00, 21'h09FFF},
        '{21'h0A000, 21'h0A4CF}, '{21'h0AC00, 21'h0D7AF}, '{21'h0F900, 21'h0FAFF},
        '{21'h0FE10, 21'h0FE1F}, '{21'h0FE30, 21'h0FE6F}, '{21'h0FF00, 21'h0FF60},
        '{21'h0FFE0, 21'h0FFE6}, '{21'h1F000, 21'h1F02F}, '{21'h1F0A0, 21'h1F0FF},
        '{21'h1F100, 21'h1F64F}, '{21'h1F680, 21'h1F6FF}, '{21'h20000, 21'h2FFFD},
        '{21'h30000, 21'h3FFFD}
    };

    // Parallel range compare against the fixed double-width table.
    function automatic logic in_wide_table(input logic [CP_W-1:0] v);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < N_WIDE; k++)
        begin
            if (v >= WIDE_RANGES[k][0] && v <= WIDE_RANGES[k][1])
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

>>> hw/rtl/utf8_stream_decoder.sv
// Top level: byte-serial UTF-8 decoder with a three-word result queue.
`timescale 1ns / 1ps

// utf8_stream_decoder takes one byte per clock on the s_ side and emits decoded
// code points on the m_ side. Each accepted byte is decoded in the cycle it is
// accepted: the open-sequence state (bytes still due, sequence length, partial
// value) updates at that edge, and the zero, one or two result words it causes
// enter a three-word result queue, and a word is registered there before it
// appears on m_. Lead bytes of multi-byte sequences give no word; a
// non-continuation byte inside an open sequence gives a truncated word first and
// is then decoded again as a fresh byte, which may give a second word. The queue
// head drives the m_ port; s_tready is high while the queue holds at most one
// word, so with a free-flowing output the block sustains one byte per cycle, and
// a byte that gives two words stalls the input while the extra word drains. Words
// carry the code point in m_tdata (zero unless valid) and the status and
// double-width flag in m_tuser; m_tlast marks the final word caused by one input byte.
module utf8_stream_decoder
    import utf8_dec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
    output logic [3:0]  m_tuser,   // [2:0] status, [3] is_wide
    output logic        m_tlast
);

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        status_t         status;
        logic            is_wide;
        logic            last;
    } res_t;

    typedef struct packed {
        logic            emit;
        res_t            res;
        logic [2:0]      seqlen;
        logic [1:0]      pending;
        logic [CP_W-1:0] partial;
    } lead_t;

    // Build one result word; code point and width flag only survive on valid.
    function automatic res_t make_res(input logic [CP_W-1:0] v, input status_t st,
                                      input logic lst);
        res_t r;
        r.code_point = (st == ST_VALID) ? v : '0;
        r.status     = st;
        r.is_wide    = (st == ST_VALID) && in_wide_table(v);
        r.last       = lst;
        return r;
    endfunction

    // Decode a byte with no sequence open.
    function automatic lead_t take_lead(input logic [7:0] b);
        lead_t l;
        l.emit    = 1'b0;
        l.res     = make_res('0, ST_BAD_LEAD, 1'b1);
        l.seqlen  = 3'd0;
        l.pending = 2'd0;
        l.partial = '0;
        if (b == 8'h00)
        begin
            l.emit = 1'b1;
            l.res  = make_res('0, ST_TERM, 1'b1);
        end
        else if (b[7] == 1'b0)
        begin
            l.emit = 1'b1;
            l.res  = make_res({13'd0, b}, ST_VALID, 1'b1);
        end
        else if (b < 8'hC0 || b >= 8'hF8)
        begin
            l.emit = 1'b1;
        end
        else if (b < 8'hE0)
        begin
            l.seqlen  = 3'd2;
            l.pending = 2'd1;
            l.partial = {16'd0, b[4:0]};
        end
        else if (b < 8'hF0)
        begin
            l.seqlen  = 3'd3;
            l.pending = 2'd2;
            l.partial = {17'd0, b[3:0]};
        end
        else
        begin
            l.seqlen  = 3'd4;
            l.pending = 2'd3;
            l.partial = {18'd0, b[2:0]};
        end
        return l;
    endfunction

    // Decoder state.
    logic [1:0]      pending_reg, pending_next;
    logic [2:0]      seqlen_reg, seqlen_next;
    logic [CP_W-1:0] partial_reg, partial_next;

    // Result queue: entry 0 is the head shown on m_.
    res_t            q_reg [0:QDEPTH-1];
    res_t            q_next [0:QDEPTH-1];
    logic [1:0]      count_reg, count_next;

    logic            s_acc;
    logic            pop;
    logic [1:0]      n_res;
    logic [1:0]      push;
    logic [1:0]      base;
    logic [1:0]      idx;
    res_t            r0, r1;
    lead_t           lead;
    logic [CP_W-1:0] v;
    status_t         fin_st;

    assign s_tready = (count_reg <= 2'd1);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;

    assign m_tdata  = {3'd0, q_reg[0].code_point};
    assign m_tuser  = {q_reg[0].is_wide, q_reg[0].status};
    assign m_tlast  = q_reg[0].last;

    // Decode the incoming byte against the open-sequence state.
    always_comb
    begin
        lead         = take_lead(s_tdata);
        v            = {partial_reg[CP_W-7:0], s_tdata[5:0]};
        fin_st       = ST_VALID;
        n_res        = 2'd0;
        r0           = lead.res;
        r1           = lead.res;
        pending_next = pending_reg;
        seqlen_next  = seqlen_reg;
        partial_next = partial_reg;

        if (v > CP_MAX)
        begin
            fin_st = ST_REJECT;
        end
        else if (v >= SURR_LO && v <= SURR_HI)
        begin
            fin_st = ST_REJECT;
        end
        else if ((seqlen_reg == 3'd2 && v < MIN_2BYTE) ||
                 (seqlen_reg == 3'd3 && v < MIN_3BYTE) ||
                 (seqlen_reg == 3'd4 && v < MIN_4BYTE))
        begin
            fin_st = ST_REJECT;
        end

        if (pending_reg != 2'd0)
        begin
            if (s_tdata[7:6] == 2'b10)
            begin
                // Continuation: gather six bits, close the sequence when none are due.
                pending_next = pending_reg - 2'd1;
                partial_next = v;
                if (pending_reg == 2'd1)
                begin
                    n_res        = 2'd1;
                    r0           = make_res(v, fin_st, 1'b1);
                    seqlen_next  = 3'd0;
                    partial_next = '0;
                end
            end
            else
            begin
                // Drop the open sequence, then decode this byte as a fresh one.
                r0           = make_res('0, ST_TRUNC, !lead.emit);
                r1           = lead.res;
                n_res        = lead.emit ? 2'd2 : 2'd1;
                pending_next = lead.pending;
                seqlen_next  = lead.seqlen;
                partial_next = lead.partial;
            end
        end
        else
        begin
            n_res        = lead.emit ? 2'd1 : 2'd0;
            r0           = lead.res;
            pending_next = lead.pending;
            seqlen_next  = lead.seqlen;
            partial_next = lead.partial;
        end

        if (!s_acc)
        begin
            pending_next = pending_reg;
            seqlen_next  = seqlen_reg;
            partial_next = partial_reg;
        end
    end

    // Queue update: shift out the head on pop, append up to two new words.
    always_comb
    begin
        push       = s_acc ? n_res : 2'd0;
        base       = count_reg - {1'b0, pop};
        count_next = base + push;
        idx        = 2'd0;
        for (int i = 0; i < QDEPTH; i++)
        begin
            idx       = 2'(i) + {1'b0, pop};
            q_next[i] = q_reg[i];
            if (2'(i) < base)
            begin
                q_next[i] = q_reg[idx];
            end
            else if (2'(i) == base && push != 2'd0)
            begin
                q_next[i] = r0;
            end
            else if (2'(i) == base + 2'd1 && push == 2'd2)
            begin
                q_next[i] = r1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            seqlen_reg  <= 3'd0;
            partial_reg <= '0;
            count_reg   <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
            seqlen_reg  <= seqlen_next;
            partial_reg <= partial_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

>>> hw/rtl/utf8_dec_checker.sv
// Port-level checker for the UTF-8 stream decoder, bound to the top level.
`timescale 1ns / 1ps

module utf8_dec_checker
    import utf8_dec_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);

    // Non-valid words carry no code point and no width flag.
    a_zero_unless_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2:0] != ST_VALID) |-> (m_tdata == 24'd0 && !m_tuser[3]))
        else $error("non-valid word carries data");

    // Valid words are Unicode scalar values.
    a_scalar_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2:0] == ST_VALID) |->
        (m_tdata <= 24'h10FFFF && (m_tdata < 24'h00D800 || m_tdata > 24'h00DFFF)))
        else $error("valid word outside scalar range");

    // A terminator word always closes its byte's results.
    a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2:0] == ST_TERM) |-> m_tlast)
        else $error("terminator word not marked last");

    // Stalled output word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
        (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled output word changed");

endmodule

bind utf8_stream_decoder utf8_dec_checker u_utf8_dec_checker (.*);
